// ===== design/counting_multiset_table_defines.svh =====
// Assertion macros shared by the counting multiset table modules.
`ifndef COUNTING_MULTISET_TABLE_DEFINES_SVH
`define COUNTING_MULTISET_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define CMT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("counting multiset table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("counting multiset table check failed");

`else

`define CMT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CMT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/cmt_pkg.sv =====
// Shared constants, codes and control/status types for the counting multiset table.
package cmt_pkg;

    // Default number of table entries
    localparam int ENTRIES_DEF = 64;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 32;

    // Request opcodes (the unused code behaves as a query)
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // capture request word, restart scan
        logic scan;     // step the key search
        logic update;   // apply result, write table, load output word
    } cmt_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_done;
    } cmt_stat_t;

endpackage

// ===== design/cmt_ctrl.sv =====
// Controller state machine: sequences load, scan and update of one request word.
module cmt_ctrl
    import cmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output cmt_cmd_t  cmd,
    input  cmt_stat_t stat
);

`include "counting_multiset_table_defines.svh"

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state and commands
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = UPDATE;
                end
            end
            UPDATE:
            begin
                // output slot must be empty or draining this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.update     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != IDLE);
    assign out_valid = out_valid_reg;

    `CMT_ASSERT_IMPLY(a_upd_slot_free, clk, rst_n, cmd.update, !out_valid_reg || !out_stall)
    `CMT_ASSERT_NEXT(a_upd_shows_word, clk, rst_n, cmd.update, out_valid_reg)
    `CMT_ASSERT_NEXT(a_load_stalls, clk, rst_n, cmd.load, in_stall)

endmodule

// ===== design/cmt_dp.sv =====
// Datapath: key/count memories, pipelined key scan, entry update and output word.
module cmt_dp
    import cmt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmt_cmd_t                  cmd,
    output cmt_stat_t                 stat,
    input  logic [1:0]                opcode,
    input  logic signed [KEY_W-1:0]   key,
    output logic [COUNT_W-1:0]        count,
    output logic [1:0]                status
);

`include "counting_multiset_table_defines.svh"

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // Table storage
    logic [KEY_W-1:0]   key_mem [ENTRIES];
    logic [COUNT_W-1:0] cnt_mem [ENTRIES];

    // Request word
    logic [1:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;

    // Scan pipeline
    logic [CW-1:0]      scan_idx_reg;
    logic [CW-1:0]      scan_idx_next;
    logic [IW-1:0]      scan_addr;
    logic               rd_valid_reg;
    logic               rd_valid_next;
    logic [IW-1:0]      rd_idx_reg;
    logic [KEY_W-1:0]   rd_key_reg;
    logic [COUNT_W-1:0] rd_cnt_reg;
    logic               issue;
    logic               match;

    // Search result
    logic               hit_reg;
    logic               hit_next;
    logic [IW-1:0]      hit_idx_reg;
    logic [COUNT_W-1:0] hit_cnt_reg;

    // Fill level and update
    logic [CW-1:0]      used_reg;
    logic [CW-1:0]      used_next;
    logic               wr_key_en;
    logic               wr_cnt_en;
    logic [IW-1:0]      wr_addr;
    logic [COUNT_W-1:0] wr_cnt;
    logic [COUNT_W-1:0] res_count;
    logic [1:0]         res_status;

    // Output word
    logic [COUNT_W-1:0] count_reg;
    logic [1:0]         status_reg;

    // Scan control: one entry read per cycle, compared in the next cycle
    assign scan_addr = scan_idx_reg[IW-1:0];
    assign match     = rd_valid_reg && !hit_reg && (rd_key_reg == key_reg);
    assign issue     = cmd.scan && !hit_reg && !match && (scan_idx_reg < used_reg);
    assign stat.scan_done = !rd_valid_reg && (hit_reg || (scan_idx_reg >= used_reg));

    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        rd_valid_next = issue;
        hit_next      = hit_reg || match;
        if (cmd.load)
        begin
            scan_idx_next = '0;
            rd_valid_next = 1'b0;
            hit_next      = 1'b0;
        end
        else if (issue)
        begin
            scan_idx_next = scan_idx_reg + CW'(1);
        end
    end

    // Result and table write for the current request
    always_comb
    begin
        wr_key_en  = 1'b0;
        wr_cnt_en  = 1'b0;
        wr_addr    = hit_idx_reg;
        wr_cnt     = hit_cnt_reg;
        used_next  = used_reg;
        res_count  = '0;
        res_status = ST_OK;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (hit_reg)
                begin
                    if (hit_cnt_reg != '1)
                    begin
                        wr_cnt = hit_cnt_reg + COUNT_W'(1);
                    end
                    wr_cnt_en = 1'b1;
                    res_count = wr_cnt;
                end
                else if (used_reg < CW'(ENTRIES))
                begin
                    wr_addr   = used_reg[IW-1:0];
                    wr_cnt    = COUNT_W'(1);
                    wr_key_en = 1'b1;
                    wr_cnt_en = 1'b1;
                    used_next = used_reg + CW'(1);
                    res_count = COUNT_W'(1);
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            OP_REMOVE:
            begin
                if (hit_reg && (hit_cnt_reg != '0))
                begin
                    wr_cnt    = hit_cnt_reg - COUNT_W'(1);
                    wr_cnt_en = 1'b1;
                    res_count = wr_cnt;
                end
                else
                begin
                    res_status = ST_ABSENT;
                end
            end
            default:
            begin
                // query, and the unused code
                if (hit_reg)
                begin
                    res_count = hit_cnt_reg;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            used_reg     <= '0;
        end
        else
        begin
            scan_idx_reg <= scan_idx_next;
            rd_valid_reg <= rd_valid_next;
            hit_reg      <= hit_next;
            if (cmd.update)
            begin
                used_reg <= used_next;
            end
        end
    end

    // Table memories, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.update && wr_key_en)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        if (cmd.update && wr_cnt_en)
        begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        rd_key_reg <= key_mem[scan_addr];
        rd_cnt_reg <= cnt_mem[scan_addr];
        rd_idx_reg <= scan_addr;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            key_reg <= $unsigned(key);
        end
        if (match)
        begin
            hit_idx_reg <= rd_idx_reg;
            hit_cnt_reg <= rd_cnt_reg;
        end
        if (cmd.update)
        begin
            count_reg  <= res_count;
            status_reg <= res_status;
        end
    end

    assign count  = count_reg;
    assign status = status_reg;

    `CMT_ASSERT_IMPLY(a_used_bound, clk, rst_n, 1'b1, used_reg <= CW'(ENTRIES))
    `CMT_ASSERT_NEXT(a_used_hold, clk, rst_n, !cmd.update, $stable(used_reg))
    `CMT_ASSERT_IMPLY(a_read_in_use, clk, rst_n, rd_valid_reg, CW'(rd_idx_reg) < used_reg)

endmodule

// ===== design/counting_multiset_table.sv =====
// Counting multiset table: keyed occurrence counters kept in a scanned entry table.
//
// Input channel (in_valid / in_stall): one word per request, opcode and key.
//   Opcode 0 inserts the key, 1 queries its count, 2 removes one occurrence;
//   code 3 acts as a query. A word is taken when in_valid is high and
//   in_stall is low; in_stall stays high while a request is in progress.
// Output channel (out_valid / out_stall): one word per request, count and
//   status (0 ok, 1 key absent or count already zero, 2 table full).
// The search reads the key memory through its single read port, one entry per
//   cycle, in order from the first entry, until the key is found or all entries
//   in use have been read; an absent key reads every entry in use.
// The next word can be taken in the cycle after the result word loads; a new
//   word is not taken before the previous request has loaded its result word.
// One request is in progress at a time; the next word is accepted while the
//   previous result still waits in the output register.
// If the receiver stalls, the output word holds; a finished request waits for
//   the output register to free before it writes the table.
// Reset empties the table at once (fill count cleared, no clearing pass).
module counting_multiset_table
    import cmt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              opcode,
    input  logic signed [KEY_W-1:0] key,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [COUNT_W-1:0]      count,
    output logic [1:0]              status
);

    cmt_cmd_t  cmd;
    cmt_stat_t stat;

    // Sequencer
    cmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Table and search datapath
    cmt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .opcode (opcode),
        .key    (key),
        .count  (count),
        .status (status)
    );

endmodule

// ===== dv/counting_multiset_table_tb.sv =====
// Self-checking testbench for the counting multiset table: directed and random requests.
`timescale 1ns / 100ps

module counting_multiset_table_tb;
    import cmt_pkg::*;

    localparam int ENTRIES = ENTRIES_DEF;
    // Unused opcode, decoded by the block as a query
    localparam logic [1:0] OP_SPARE = 2'd3;
    // Random phase keeps this many entries or fewer before the fill test
    localparam int SPARSE_LIMIT = 40;

    typedef struct packed {
        logic [COUNT_W-1:0] cnt;
        logic [1:0]         st;
    } table_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [1:0]              opcode = OP_QUERY;
    logic signed [KEY_W-1:0] key = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [COUNT_W-1:0]      count;
    logic [1:0]              status;

    // Shadow copy of the table, updated as each request word is accepted
    logic [KEY_W-1:0]   shadow_key [ENTRIES];
    logic [COUNT_W-1:0] shadow_cnt [ENTRIES];
    int                 shadow_used = 0;

    table_result_t pending_results [$];
    table_result_t oldest;
    int            errors = 0;
    int            burst_left = 0;
    int            hold_left = 0;
    int            stall_mode = 0;
    int            stall_run = 0;

    counting_multiset_table #(.ENTRIES(ENTRIES)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .count     (count),
        .status    (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Index of the entry in use that holds k, or -1
    function automatic int find_entry(logic [KEY_W-1:0] k);
        for (int i = 0; i < shadow_used; i++)
        begin
            if (shadow_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    // Expected result word of one request; applies the request to the shadow table
    function automatic table_result_t apply_request(logic [1:0] op, logic [KEY_W-1:0] k);
        int            hit;
        table_result_t r;
        hit = find_entry(k);
        r.cnt = '0;
        r.st = ST_OK;
        if (op == OP_INSERT)
        begin
            if (hit >= 0)
            begin
                if (shadow_cnt[hit] != '1)
                    shadow_cnt[hit] = shadow_cnt[hit] + 1'b1;
                r.cnt = shadow_cnt[hit];
            end
            else if (shadow_used < ENTRIES)
            begin
                shadow_key[shadow_used] = k;
                shadow_cnt[shadow_used] = 1;
                shadow_used++;
                r.cnt = 1;
            end
            else
                r.st = ST_FULL;
        end
        else if (op == OP_REMOVE)
        begin
            if (hit >= 0 && shadow_cnt[hit] != '0)
            begin
                shadow_cnt[hit] = shadow_cnt[hit] - 1'b1;
                r.cnt = shadow_cnt[hit];
            end
            else
                r.st = ST_ABSENT;
        end
        else if (hit >= 0)
            r.cnt = shadow_cnt[hit];
        return r;
    endfunction

    // Random key: mostly one already in the table, else a fresh 32-bit value
    function automatic logic [KEY_W-1:0] pick_key();
        if (shadow_used > 0 && $urandom_range(0, 99) < 75)
            return shadow_key[$urandom_range(0, shadow_used - 1)];
        return $urandom();
    endfunction

    function automatic logic [1:0] pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return OP_INSERT;
        if (r < 65)
            return OP_QUERY;
        if (r < 95)
            return OP_REMOVE;
        return OP_SPARE;
    endfunction

    // Offer one request word and hold it until taken
    task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] k);
        in_valid <= 1'b1;
        opcode <= op;
        key <= k;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(apply_request(op, k));
    endtask

    // Sender pacing: bursts of random length, random gaps between them
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Extreme keys, every opcode, zero counts and absent keys
    task automatic test_directed();
        send_request(OP_INSERT, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 32'h8000_0000);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_INSERT, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_QUERY, 32'h7FFF_FFFF);
        send_request(OP_QUERY, 32'h8000_0000);
        send_request(OP_QUERY, 32'h0000_0000);
        send_request(OP_QUERY, 32'h0001_2345);
        send_request(OP_SPARE, 32'hFFFF_FFFF);
        send_request(OP_SPARE, 32'h5555_AAAA);
        send_request(OP_REMOVE, 32'hAAAA_5555);
        send_request(OP_REMOVE, 32'hFFFF_FFFF);
        // count now zero: remove must flag, query must report zero
        send_request(OP_REMOVE, 32'hFFFF_FFFF);
        send_request(OP_QUERY, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 32'h0000_0000);
        send_request(OP_REMOVE, 32'h0000_0000);
        send_request(OP_REMOVE, 32'h0000_0000);
        wait_for_results();
    endtask

    // Random traffic with the table partly filled
    task automatic test_random_sparse(input int n);
        logic [1:0]       op;
        logic [KEY_W-1:0] k;
        for (int i = 0; i < n; i++)
        begin
            op = pick_opcode();
            k = pick_key();
            if (op == OP_INSERT && shadow_used >= SPARSE_LIMIT && find_entry(k) < 0)
                k = shadow_key[$urandom_range(0, shadow_used - 1)];
            send_request(op, k);
            pace();
        end
    endtask

    // Receiver holds off while words keep coming, then the results drain
    task automatic test_backpressure();
        hold_left = 400;
        for (int i = 0; i < 12; i++)
            send_request(pick_opcode(), pick_key());
        wait_for_results();
    endtask

    // Fill every entry, then query and insert a stored key; inserts of new keys must report a full table
    task automatic test_fill();
        logic [KEY_W-1:0] k;
        while (shadow_used < ENTRIES)
        begin
            k = $urandom();
            if (find_entry(k) < 0)
                send_request(OP_INSERT, k);
        end
        send_request(OP_QUERY, shadow_key[ENTRIES - 1]);
        send_request(OP_INSERT, shadow_key[ENTRIES - 1]);
        for (int i = 0; i < 4; i++)
        begin
            k = $urandom();
            if (find_entry(k) < 0)
                send_request(OP_INSERT, k);
        end
        wait_for_results();
    endtask

    // Random traffic against the full table
    task automatic test_random_full(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_request(pick_opcode(), pick_key());
            pace();
        end
    endtask

    // Receiver stall pattern, with a counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            if (stall_run == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_run = $urandom_range(10, 80);
            end
            stall_run--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 1);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word: count=%0d status=%0d",
                         $time, count, status);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (count !== oldest.cnt)
                begin
                    errors++;
                    $display("%0t: count mismatch: expected %0d actual %0d",
                             $time, oldest.cnt, count);
                end
                if (status !== oldest.st)
                begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, oldest.st, status);
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_sparse(700);
        test_backpressure();
        test_fill();
        test_random_full(850);
        wait_for_results();
        repeat (ENTRIES + 8) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/cmt_pkg.sv
design/cmt_ctrl.sv
design/cmt_dp.sv
design/counting_multiset_table.sv
dv/counting_multiset_table_tb.sv
